FILE: sv/brb_pkg.sv
package brb_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_READERS = 8;
    localparam int DATA_WIDTH  = 16;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int RID_W   = 3;
    localparam int RCNT_W  = 4;
    localparam int RLEN_W  = 5;
    localparam int CNT_W   = $clog2(MAX_READERS + 1);
    localparam int LEN_W   = $clog2(DEPTH + 1);
    localparam int CFG_W   = (RCNT_W > RLEN_W) ? RCNT_W : RLEN_W;
    localparam int IUSER_W = 1 + RID_W;
    localparam int OUSER_W = 2;

    typedef enum logic {
        CFG_READER_COUNT = 1'b0,
        CFG_RING_LENGTH  = 1'b1
    } t_cfg_index;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BAD_ID = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_BAD_ID = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                         kind;
        logic [RID_W-1:0]              reader_id;
        logic signed [DATA_WIDTH-1:0]  write_value;
    } t_cmd;

    function automatic logic [CNT_W-1:0] eff_readers(input logic [RCNT_W-1:0] cnt);
        logic [CNT_W-1:0] res;
        if (cnt == '0) begin
            res = CNT_W'(1);
        end else if (32'(cnt) > MAX_READERS) begin
            res = CNT_W'(MAX_READERS);
        end else begin
            res = CNT_W'(cnt);
        end
        return res;
    endfunction

    function automatic logic [LEN_W-1:0] eff_length(input logic [RLEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (32'(len) > DEPTH) begin
            res = LEN_W'(DEPTH);
        end else begin
            res = LEN_W'(len);
        end
        return res;
    endfunction

endpackage

FILE: sv/broadcast_ring_buffer_unit.sv
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata write_value, tuser opcode, reader_id
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata read_value, tuser status
// cfg       in         i_cfg_we                     i_cfg_addr, i_cfg_data
//
// One item per cycle sustained while m_axis_tready stays high; an item passes
// through the two-entry command queue and then the registered execute stage.
// Each item touches at most one slot and one pointer in the execute stage.
// Synchronous active-low reset empties the ring, zeroes every pointer and lap
// and sets reader_count to 1 and ring_length to 16.
// Output stall backs up the queue; s_axis_tready drops once both entries fill.
module broadcast_ring_buffer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [brb_pkg::DATA_WIDTH-1:0]      s_axis_tdata,   // [15:0] write_value
    input  logic [brb_pkg::IUSER_W-1:0]         s_axis_tuser,   // [0] opcode, [3:1] reader_id
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [brb_pkg::DATA_WIDTH-1:0]      m_axis_tdata,   // [15:0] read_value
    output logic [brb_pkg::OUSER_W-1:0]         m_axis_tuser,   // [1:0] status
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_addr,
    input  logic [brb_pkg::CFG_W-1:0]           i_cfg_data
);

    logic [brb_pkg::RCNT_W-1:0] r_reader_count;
    logic [brb_pkg::RLEN_W-1:0] r_ring_length;
    logic [brb_pkg::CNT_W-1:0]  need;
    logic [brb_pkg::LEN_W-1:0]  len;
    logic                       cmd_valid;
    logic                       cmd_take;
    brb_pkg::t_cmd              cmd;
    logic signed [brb_pkg::DATA_WIDTH-1:0] read_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reader_count <= brb_pkg::RCNT_W'(1);
            r_ring_length  <= brb_pkg::RLEN_W'(16);
        end else if (i_cfg_we) begin
            unique case (brb_pkg::t_cfg_index'(i_cfg_addr))
                brb_pkg::CFG_READER_COUNT: r_reader_count <= i_cfg_data[brb_pkg::RCNT_W-1:0];
                brb_pkg::CFG_RING_LENGTH:  r_ring_length  <= i_cfg_data[brb_pkg::RLEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign need = brb_pkg::eff_readers(r_reader_count);
    assign len  = brb_pkg::eff_length(r_ring_length);

    brb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_opcode      (s_axis_tuser[0]),
        .i_reader_id   (s_axis_tuser[brb_pkg::RID_W:1]),
        .i_write_value (s_axis_tdata),
        .i_need        (need),
        .o_cmd_valid   (cmd_valid),
        .i_cmd_take    (cmd_take),
        .o_cmd         (cmd)
    );

    brb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .o_cmd_take   (cmd_take),
        .i_cmd        (cmd),
        .i_need       (need),
        .i_len        (len),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_status     (m_axis_tuser),
        .o_read_value (read_value)
    );

    assign m_axis_tdata = read_value;

endmodule

FILE: sv/brb_front.sv
module brb_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_opcode,
    input  logic [brb_pkg::RID_W-1:0]       i_reader_id,
    input  logic signed [brb_pkg::DATA_WIDTH-1:0] i_write_value,
    input  logic [brb_pkg::CNT_W-1:0]       i_need,
    output logic                            o_cmd_valid,
    input  logic                            i_cmd_take,
    output brb_pkg::t_cmd                   o_cmd
);

    brb_pkg::t_cmd r_q [2];
    logic          r_wr_idx;
    logic          r_rd_idx;
    logic [1:0]    r_count;
    brb_pkg::t_cmd n_cmd;
    logic          push;
    logic          pop;

    assign o_ready     = (r_count != 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_idx];
    assign push        = i_valid && o_ready;
    assign pop         = i_cmd_take && o_cmd_valid;

    // classify
    always_comb begin
        n_cmd.reader_id   = i_reader_id;
        n_cmd.write_value = i_write_value;
        if (brb_pkg::t_opcode'(i_opcode) == brb_pkg::OP_WRITE) begin
            n_cmd.kind = brb_pkg::KIND_WRITE;
        end else if (brb_pkg::CNT_W'(i_reader_id) >= i_need) begin
            n_cmd.kind = brb_pkg::KIND_BAD_ID;
        end else begin
            n_cmd.kind = brb_pkg::KIND_READ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_idx] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= 1'b0;
            r_rd_idx <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_idx <= ~r_wr_idx;
            end
            if (pop) begin
                r_rd_idx <= ~r_rd_idx;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/brb_back.sv
module brb_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_take,
    input  brb_pkg::t_cmd                   i_cmd,
    input  logic [brb_pkg::CNT_W-1:0]       i_need,
    input  logic [brb_pkg::LEN_W-1:0]       i_len,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_status,
    output logic signed [brb_pkg::DATA_WIDTH-1:0] o_read_value
);

    logic signed [brb_pkg::DATA_WIDTH-1:0] r_data [brb_pkg::DEPTH];
    logic [brb_pkg::CNT_W-1:0] r_reads  [brb_pkg::DEPTH];
    logic [brb_pkg::DEPTH-1:0] r_filled;
    logic [brb_pkg::DEPTH-1:0] r_slap;
    logic [brb_pkg::PTR_W-1:0] r_wptr;
    logic                      r_wlap;
    logic [brb_pkg::PTR_W-1:0] r_rptr [brb_pkg::MAX_READERS];
    logic [brb_pkg::MAX_READERS-1:0] r_rlap;

    logic                      r_out_valid;
    brb_pkg::t_status          r_out_status;
    logic signed [brb_pkg::DATA_WIDTH-1:0] r_out_value;

    logic                      take;
    logic                      is_write;
    logic                      is_read;
    logic [brb_pkg::PTR_W-1:0] rptr;
    logic                      rlap;
    logic [brb_pkg::PTR_W-1:0] slot;
    logic                      writable;
    logic                      readable;
    logic [brb_pkg::PTR_W-1:0] ptr_in;
    logic                      lap_in;
    logic [brb_pkg::PTR_W:0]   ptr_inc;
    logic [brb_pkg::PTR_W-1:0] n_ptr;
    logic                      n_lap;
    brb_pkg::t_status          n_status;
    logic signed [brb_pkg::DATA_WIDTH-1:0] n_value;

    assign take       = i_cmd_valid && (!r_out_valid || i_ready);
    assign o_cmd_take = take;
    assign is_write   = (i_cmd.kind == brb_pkg::KIND_WRITE);
    assign is_read    = (i_cmd.kind == brb_pkg::KIND_READ);
    assign rptr       = r_rptr[i_cmd.reader_id];
    assign rlap       = r_rlap[i_cmd.reader_id];
    assign slot       = is_write ? r_wptr : rptr;
    assign writable   = !r_filled[slot] || (r_reads[slot] >= i_need);
    assign readable   = r_filled[slot] && (r_reads[slot] < i_need) && (r_slap[slot] == rlap);

    // advance the pointer that this item moves
    assign ptr_in  = is_write ? r_wptr : rptr;
    assign lap_in  = is_write ? r_wlap : rlap;
    assign ptr_inc = {1'b0, ptr_in} + (brb_pkg::PTR_W+1)'(1);
    always_comb begin
        if (brb_pkg::LEN_W'(ptr_inc) >= i_len) begin
            n_ptr = '0;
            n_lap = ~lap_in;
        end else begin
            n_ptr = ptr_inc[brb_pkg::PTR_W-1:0];
            n_lap = lap_in;
        end
    end

    always_comb begin
        n_value = '0;
        unique case (i_cmd.kind)
            brb_pkg::KIND_WRITE:  n_status = writable ? brb_pkg::ST_DONE : brb_pkg::ST_FULL;
            brb_pkg::KIND_READ: begin
                n_status = readable ? brb_pkg::ST_DONE : brb_pkg::ST_EMPTY;
                if (readable) begin
                    n_value = r_data[slot];
                end
            end
            default:              n_status = brb_pkg::ST_BAD_ID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take && is_write && writable) begin
            r_data[slot] <= i_cmd.write_value;
        end
        if (take) begin
            r_out_status <= n_status;
            r_out_value  <= n_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled    <= '0;
            r_slap      <= '0;
            r_wptr      <= '0;
            r_wlap      <= 1'b0;
            r_rlap      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < brb_pkg::DEPTH; i++) begin
                r_reads[i] <= '0;
            end
            for (int i = 0; i < brb_pkg::MAX_READERS; i++) begin
                r_rptr[i] <= '0;
            end
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (take && is_write && writable) begin
                r_reads[slot]  <= '0;
                r_filled[slot] <= 1'b1;
                r_slap[slot]   <= r_wlap;
                r_wptr         <= n_ptr;
                r_wlap         <= n_lap;
            end
            if (take && is_read && readable) begin
                r_reads[slot]               <= r_reads[slot] + brb_pkg::CNT_W'(1);
                r_rptr[i_cmd.reader_id]     <= n_ptr;
                r_rlap[i_cmd.reader_id]     <= n_lap;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_value;

endmodule

FILE: sv/brb_checker.sv
module brb_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [brb_pkg::DATA_WIDTH-1:0]  m_axis_tdata,
    input  logic [brb_pkg::OUSER_W-1:0]     m_axis_tuser
);

    logic [2:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 3'd0;
        end else begin
            r_pending <= r_pending + 3'(in_acc) - 3'(out_acc);
        end
    end

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_pending != 3'd0))
        else $error("result without a pending item");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd3)
        else $error("more items in flight than storage");

    a_zero_on_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != brb_pkg::ST_DONE)) |-> (m_axis_tdata == '0))
        else $error("refused item carries data");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind broadcast_ring_buffer_unit brb_checker u_brb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
